// ===== src/planar_body_motion_step_top_defines.svh =====
// assertion macros for the planar body motion step block
// used by the port checker, needs clk_i and rst_ni in scope
`ifndef PLANAR_BODY_MOTION_STEP_TOP_DEFINES_SVH
`define PLANAR_BODY_MOTION_STEP_TOP_DEFINES_SVH

// checked only while out of reset
`define PBMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define PBMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/pbms_pkg.sv =====
// shared types, constants and helper functions of the planar body motion step
// no dependencies
package pbms_pkg;

  localparam int unsigned CfgIdxW = 3;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MASS  = 3'd0,
    CFG_START = 3'd1,
    CFG_LIMIT = 3'd2,
    CFG_FRIC  = 3'd3,
    CFG_GEN   = 3'd4,
    CFG_GX    = 3'd5,
    CFG_GY    = 3'd6
  } cfg_idx_e;

  // 0.01 in Q32.32, rounded to nearest
  localparam logic [63:0] STILL_SQ_LIMIT = 64'd42949673;

  localparam int unsigned DivSteps  = 64;
  localparam int unsigned SqrtSteps = 32;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DIV,
    S_SQRT,
    S_AX,
    S_AY,
    S_GRAV,
    S_SQ0,
    S_SQ1,
    S_CHK,
    S_SA0,
    S_SA1,
    S_LXM,
    S_LX,
    S_LY,
    S_MX,
    S_AXV,
    S_MY,
    S_AYV,
    S_CLAMP,
    S_FM,
    S_FM2,
    S_FA,
    S_PXM,
    S_PXA,
    S_PYM,
    S_PYA,
    S_DONE
  } state_e;

  // magnitude of a signed word, full range
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  // signed word from a sign and a magnitude, saturated
  function automatic logic signed [31:0] from_mag(input logic neg, input logic [63:0] m);
    logic [31:0] c;
    c = (m > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : m[31:0];
    if (neg) begin
      from_mag = ~c + 32'd1;
    end else if (c[31]) begin
      from_mag = 32'h7fff_ffff;
    end else begin
      from_mag = c;
    end
  endfunction

  // clamp a 33-bit sum to the signed word range
  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      sat32 = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== src/planar_body_motion_step_top.sv =====
// planar body motion step, top level and only design module
// depends on pbms_pkg
//
// One word in gives one word out: the new position and velocity of the body after
// the tick. Products, quotients and roots run through one multiplier, one restoring
// divider that makes one quotient bit a cycle, and a square root unit that makes one
// root bit a cycle, stepped by a sequencer. A plain tick runs two force divisions, a
// tick with ground friction one division more, and a launch of a resting body a square
// root and two divisions more. The input is stalled from acceptance until the result
// word is taken.
module planar_body_motion_step_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pbms_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [31:0]                          cfg_data_i,
  // input words
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [31:0]                   force_x_i,
  input  logic signed [31:0]                   force_y_i,
  input  logic [16:0]                          time_step_i,
  input  logic                                 on_ground_i,
  // result words
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [31:0]                   pos_x_o,
  output logic signed [31:0]                   pos_y_o,
  output logic signed [31:0]                   vel_x_o,
  output logic signed [31:0]                   vel_y_o
);

  pbms_pkg::state_e state_q, state_d, ret_q;

  // configuration registers
  logic [30:0]        mass_q, start_q, limit_q, fric_q;
  logic               gen_q;
  logic signed [31:0] gx_q, gy_q;

  // body state
  logic signed [31:0] vx_q, vy_q, px_q, py_q;

  // latched input word and working values
  logic signed [31:0] fx_q, fy_q, ax_q, ay_q;
  logic [16:0]        dt_q;
  logic               gnd_q;
  logic [63:0]        acc_q;

  // divider and square root registers
  logic [63:0] quo_q;
  logic [31:0] rem_q, den_q, root_q;
  logic [32:0] srem_q;
  logic [5:0]  cnt_q;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      pbms_pkg::S_SQ0: begin
        mul_a = pbms_pkg::mag32(vx_q);
        mul_b = pbms_pkg::mag32(vx_q);
      end
      pbms_pkg::S_SQ1: begin
        mul_a = pbms_pkg::mag32(vy_q);
        mul_b = pbms_pkg::mag32(vy_q);
      end
      pbms_pkg::S_SA0: begin
        mul_a = pbms_pkg::mag32(ax_q);
        mul_b = pbms_pkg::mag32(ax_q);
      end
      pbms_pkg::S_SA1: begin
        mul_a = pbms_pkg::mag32(ay_q);
        mul_b = pbms_pkg::mag32(ay_q);
      end
      pbms_pkg::S_LXM: begin
        mul_a = pbms_pkg::mag32(ax_q);
        mul_b = {1'b0, start_q};
      end
      pbms_pkg::S_LX: begin
        mul_a = pbms_pkg::mag32(ay_q);
        mul_b = {1'b0, start_q};
      end
      pbms_pkg::S_MX: begin
        mul_a = pbms_pkg::mag32(ax_q);
        mul_b = {15'd0, dt_q};
      end
      pbms_pkg::S_MY: begin
        mul_a = pbms_pkg::mag32(ay_q);
        mul_b = {15'd0, dt_q};
      end
      pbms_pkg::S_FM2: begin
        mul_a = ax_q;
        mul_b = {15'd0, dt_q};
      end
      pbms_pkg::S_PXM: begin
        mul_a = pbms_pkg::mag32(vx_q);
        mul_b = {15'd0, dt_q};
      end
      pbms_pkg::S_PYM: begin
        mul_a = pbms_pkg::mag32(vy_q);
        mul_b = {15'd0, dt_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // divider step: one quotient bit
  logic [32:0] div_sh;
  logic        div_ge;
  assign div_sh = {rem_q, quo_q[63]};
  assign div_ge = div_sh >= {1'b0, den_q};

  // square root step: one root bit
  logic [34:0] sq_sh, sq_trial;
  logic        sq_ge;
  assign sq_sh    = {srem_q, quo_q[63:62]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  // speed clamp and friction test
  logic signed [31:0] vx_cl;
  logic               fric_on;
  always_comb begin
    vx_cl = vx_q;
    if (pbms_pkg::mag32(vx_q) > {1'b0, limit_q}) begin
      vx_cl = vx_q[31] ? (~{1'b0, limit_q} + 32'd1) : {1'b0, limit_q};
    end
  end
  assign fric_on = (fx_q == '0) && (fy_q == '0) && (vx_cl != '0) && gnd_q;

  // friction step from the scaled product
  logic signed [31:0] fstep;
  assign fstep = pbms_pkg::from_mag(1'b0, {16'd0, acc_q[63:16]});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pbms_pkg::S_IDLE:  if (in_acc) state_d = pbms_pkg::S_DIV;
      pbms_pkg::S_DIV:   if (cnt_q == '0) state_d = ret_q;
      pbms_pkg::S_SQRT:  if (cnt_q == '0) state_d = ret_q;
      pbms_pkg::S_AX:    state_d = pbms_pkg::S_DIV;
      pbms_pkg::S_AY:    state_d = pbms_pkg::S_GRAV;
      pbms_pkg::S_GRAV:  state_d = pbms_pkg::S_SQ0;
      pbms_pkg::S_SQ0:   state_d = pbms_pkg::S_SQ1;
      pbms_pkg::S_SQ1:   state_d = pbms_pkg::S_CHK;
      pbms_pkg::S_CHK: begin
        if (acc_q < pbms_pkg::STILL_SQ_LIMIT) begin
          state_d = ((ax_q != '0) || (ay_q != '0)) ? pbms_pkg::S_SA0 : pbms_pkg::S_CLAMP;
        end else begin
          state_d = pbms_pkg::S_MX;
        end
      end
      pbms_pkg::S_SA0:   state_d = pbms_pkg::S_SA1;
      pbms_pkg::S_SA1:   state_d = pbms_pkg::S_SQRT;
      pbms_pkg::S_LXM:   state_d = pbms_pkg::S_DIV;
      pbms_pkg::S_LX:    state_d = pbms_pkg::S_DIV;
      pbms_pkg::S_LY:    state_d = pbms_pkg::S_CLAMP;
      pbms_pkg::S_MX:    state_d = pbms_pkg::S_AXV;
      pbms_pkg::S_AXV:   state_d = pbms_pkg::S_MY;
      pbms_pkg::S_MY:    state_d = pbms_pkg::S_AYV;
      pbms_pkg::S_AYV:   state_d = pbms_pkg::S_CLAMP;
      pbms_pkg::S_CLAMP: state_d = fric_on ? pbms_pkg::S_DIV : pbms_pkg::S_PXM;
      pbms_pkg::S_FM:    state_d = pbms_pkg::S_FM2;
      pbms_pkg::S_FM2:   state_d = pbms_pkg::S_FA;
      pbms_pkg::S_FA:    state_d = pbms_pkg::S_PXM;
      pbms_pkg::S_PXM:   state_d = pbms_pkg::S_PXA;
      pbms_pkg::S_PXA:   state_d = pbms_pkg::S_PYM;
      pbms_pkg::S_PYM:   state_d = pbms_pkg::S_PYA;
      pbms_pkg::S_PYA:   state_d = pbms_pkg::S_DONE;
      pbms_pkg::S_DONE:  if (!out_stall_i) state_d = pbms_pkg::S_IDLE;
      default:           state_d = pbms_pkg::S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_stall_o  = (state_q != pbms_pkg::S_IDLE);
    out_valid_o = (state_q == pbms_pkg::S_DONE);
  end

  assign pos_x_o = px_q;
  assign pos_y_o = py_q;
  assign vel_x_o = vx_q;
  assign vel_y_o = vy_q;

  // control and body state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbms_pkg::S_IDLE;
      ret_q   <= pbms_pkg::S_IDLE;
      cnt_q   <= '0;
      mass_q  <= 31'd65536;
      start_q <= '0;
      limit_q <= '0;
      fric_q  <= '0;
      gen_q   <= 1'b0;
      gx_q    <= '0;
      gy_q    <= '0;
      vx_q    <= '0;
      vy_q    <= '0;
      px_q    <= '0;
      py_q    <= '0;
    end else begin
      state_q <= state_d;

      // configuration writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          pbms_pkg::CFG_MASS:  mass_q  <= cfg_data_i[30:0];
          pbms_pkg::CFG_START: start_q <= cfg_data_i[30:0];
          pbms_pkg::CFG_LIMIT: limit_q <= cfg_data_i[30:0];
          pbms_pkg::CFG_FRIC:  fric_q  <= cfg_data_i[30:0];
          pbms_pkg::CFG_GEN:   gen_q   <= cfg_data_i[0];
          pbms_pkg::CFG_GX:    gx_q    <= cfg_data_i;
          pbms_pkg::CFG_GY:    gy_q    <= cfg_data_i;
          default: ;
        endcase
      end

      case (state_q)
        pbms_pkg::S_IDLE: begin
          if (in_acc) begin
            cnt_q <= 6'(pbms_pkg::DivSteps - 1);
            ret_q <= pbms_pkg::S_AX;
          end
        end
        pbms_pkg::S_DIV, pbms_pkg::S_SQRT: cnt_q <= cnt_q - 6'd1;
        pbms_pkg::S_AX: begin
          cnt_q <= 6'(pbms_pkg::DivSteps - 1);
          ret_q <= pbms_pkg::S_AY;
        end
        pbms_pkg::S_SA1: begin
          cnt_q <= 6'(pbms_pkg::SqrtSteps - 1);
          ret_q <= pbms_pkg::S_LXM;
        end
        pbms_pkg::S_LXM: begin
          cnt_q <= 6'(pbms_pkg::DivSteps - 1);
          ret_q <= pbms_pkg::S_LX;
        end
        pbms_pkg::S_LX: begin
          vx_q  <= pbms_pkg::from_mag(ax_q[31], quo_q);
          cnt_q <= 6'(pbms_pkg::DivSteps - 1);
          ret_q <= pbms_pkg::S_LY;
        end
        pbms_pkg::S_LY:  vy_q <= pbms_pkg::from_mag(ay_q[31], quo_q);
        pbms_pkg::S_AXV: vx_q <= pbms_pkg::sat32(33'(vx_q) +
                                   33'(pbms_pkg::from_mag(ax_q[31], {16'd0, acc_q[63:16]})));
        pbms_pkg::S_AYV: vy_q <= pbms_pkg::sat32(33'(vy_q) +
                                   33'(pbms_pkg::from_mag(ay_q[31], {16'd0, acc_q[63:16]})));
        pbms_pkg::S_CLAMP: begin
          vx_q  <= vx_cl;
          cnt_q <= 6'(pbms_pkg::DivSteps - 1);
          ret_q <= pbms_pkg::S_FM;
        end
        pbms_pkg::S_FA: begin
          if (pbms_pkg::mag32(vx_q) < fstep) begin
            vx_q <= '0;
          end else begin
            vx_q <= vx_q[31] ? (vx_q + fstep) : (vx_q - fstep);
          end
        end
        pbms_pkg::S_PXA: px_q <= pbms_pkg::sat32(33'(px_q) +
                                   33'(pbms_pkg::from_mag(vx_q[31], {16'd0, acc_q[63:16]})));
        pbms_pkg::S_PYA: py_q <= pbms_pkg::sat32(33'(py_q) +
                                   33'(pbms_pkg::from_mag(vy_q[31], {16'd0, acc_q[63:16]})));
        default: ;
      endcase
    end
  end

  // working datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      pbms_pkg::S_IDLE: begin
        if (in_acc) begin
          fx_q  <= force_x_i;
          fy_q  <= force_y_i;
          dt_q  <= time_step_i;
          gnd_q <= on_ground_i;
          quo_q <= {16'd0, pbms_pkg::mag32(force_x_i), 16'd0};
          rem_q <= '0;
          den_q <= {1'b0, mass_q};
        end
      end
      pbms_pkg::S_DIV: begin
        rem_q <= div_ge ? 32'(div_sh - {1'b0, den_q}) : div_sh[31:0];
        quo_q <= {quo_q[62:0], div_ge};
      end
      pbms_pkg::S_SQRT: begin
        srem_q <= sq_ge ? 33'(sq_sh - sq_trial) : sq_sh[32:0];
        root_q <= {root_q[30:0], sq_ge};
        quo_q  <= {quo_q[61:0], 2'b00};
      end
      pbms_pkg::S_AX: begin
        ax_q  <= (fx_q == '0) ? '0 : pbms_pkg::from_mag(fx_q[31], quo_q);
        quo_q <= {16'd0, pbms_pkg::mag32(fy_q), 16'd0};
        rem_q <= '0;
      end
      pbms_pkg::S_AY: ay_q <= (fy_q == '0) ? '0 : pbms_pkg::from_mag(fy_q[31], quo_q);
      pbms_pkg::S_GRAV: begin
        if (gen_q && !gnd_q) begin
          ax_q <= pbms_pkg::sat32(33'(ax_q) + 33'(gx_q));
          ay_q <= pbms_pkg::sat32(33'(ay_q) + 33'(gy_q));
        end
      end
      pbms_pkg::S_SQ0, pbms_pkg::S_SA0, pbms_pkg::S_MX, pbms_pkg::S_MY,
      pbms_pkg::S_FM2, pbms_pkg::S_PXM, pbms_pkg::S_PYM: acc_q <= prod;
      pbms_pkg::S_SQ1: acc_q <= acc_q + prod;
      pbms_pkg::S_SA1: begin
        quo_q  <= acc_q + prod;
        srem_q <= '0;
        root_q <= '0;
      end
      pbms_pkg::S_LXM, pbms_pkg::S_LX: begin
        quo_q <= prod;
        rem_q <= '0;
        den_q <= root_q;
      end
      pbms_pkg::S_CLAMP: begin
        quo_q <= {17'd0, fric_q, 16'd0};
        rem_q <= '0;
        den_q <= {1'b0, mass_q};
      end
      // friction quotient parks in ax_q, acceleration is no longer needed
      pbms_pkg::S_FM: ax_q <= (fric_q == '0) ? '0 : pbms_pkg::from_mag(1'b0, quo_q);
      default: ;
    endcase
  end

endmodule

// ===== src/pbms_checker.sv =====
// port-level checker for the planar body motion step, bound to the top level
// depends on planar_body_motion_step_top_defines.svh
`include "planar_body_motion_step_top_defines.svh"

module pbms_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic [pbms_pkg::CfgIdxW-1:0]       cfg_index_i,
  input logic [31:0]                        cfg_data_i,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic signed [31:0]                 force_x_i,
  input logic signed [31:0]                 force_y_i,
  input logic [16:0]                        time_step_i,
  input logic                               on_ground_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic signed [31:0]                 pos_x_o,
  input logic signed [31:0]                 pos_y_o,
  input logic signed [31:0]                 vel_x_o,
  input logic signed [31:0]                 vel_y_o
);

  // a pending result word stays offered
  `PBMS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result word dropped")

  // busy right after an input word is taken
  `PBMS_ASSERT(a_busy_after_in, in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o, "not busy")

  // no new input word while a result waits
  `PBMS_ASSERT(a_no_in_while_out, out_valid_o |-> in_stall_o, "input taken while result pending")

  // result word goes away once taken
  `PBMS_ASSERT(a_out_once, out_valid_o && !out_stall_i |=> !out_valid_o, "result word repeated")

  // reset clears the result side
  `PBMS_ASSERT_ALWAYS(a_reset_clear, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind planar_body_motion_step_top pbms_checker u_pbms_checker (.*);

// ===== verif/tb.sv =====
// testbench for the planar body motion step block
// drives words in and out, predicts every result word in a scoreboard class
// depends on pbms_pkg and planar_body_motion_step_top
`timescale 1ns / 1ps

module tb;

  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned SettleCycles = 500;
  localparam longint unsigned StillLimit = 64'd42949673;

  typedef struct {
    int pos_x;
    int pos_y;
    int vel_x;
    int vel_y;
  } motion_t;

  // scoreboard: own copy of the body state and registers, queue of expected words
  class motion_scoreboard;
    int mass, start, limit, fric, grav_x, grav_y;
    bit grav_on;
    int vel_x, vel_y, pos_x, pos_y;
    motion_t motion_q[$];
    int errors;

    function new();
      mass = 65536;
      start = 0;
      limit = 0;
      fric = 0;
      grav_on = 0;
      grav_x = 0;
      grav_y = 0;
      vel_x = 0;
      vel_y = 0;
      pos_x = 0;
      pos_y = 0;
      errors = 0;
    endfunction

    function void write_reg(pbms_pkg::cfg_idx_e idx, logic [31:0] data);
      case (idx)
        pbms_pkg::CFG_MASS: mass = int'({1'b0, data[30:0]});
        pbms_pkg::CFG_START: start = int'({1'b0, data[30:0]});
        pbms_pkg::CFG_LIMIT: limit = int'({1'b0, data[30:0]});
        pbms_pkg::CFG_FRIC: fric = int'({1'b0, data[30:0]});
        pbms_pkg::CFG_GEN: grav_on = data[0];
        pbms_pkg::CFG_GX: grav_x = int'(data);
        pbms_pkg::CFG_GY: grav_y = int'(data);
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned magn(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function longint signed_of(bit neg, longint unsigned m);
      longint unsigned c;
      c = (m > 64'h8000_0000) ? 64'h8000_0000 : m;
      return clamp32(neg ? -longint'(c) : longint'(c));
    endfunction

    function longint over_mass(longint num);
      longint unsigned m, q;
      m = magn(num);
      if (m == 0) return 0;
      if (mass == 0) q = 64'h8000_0000;
      else q = (m << 16) / longint'(mass);
      return signed_of(num < 0, q);
    endfunction

    function longint times_dt(longint v, longint unsigned dt);
      return signed_of(v < 0, (magn(v) * dt) >> 16);
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // advance the body one tick and queue the word it must produce
    function void note_tick(int fx, int fy, logic [16:0] dt_bits, bit ground);
      longint ax, ay, vx, vy, f;
      longint unsigned sq, m, dt;
      motion_t w;
      dt = dt_bits;
      ax = over_mass(fx);
      ay = over_mass(fy);
      if (grav_on && !ground) begin
        ax = clamp32(ax + grav_x);
        ay = clamp32(ay + grav_y);
      end
      vx = vel_x;
      vy = vel_y;
      sq = magn(vx) * magn(vx) + magn(vy) * magn(vy);
      // near-still body launches along the acceleration
      if (sq < StillLimit) begin
        if (ax != 0 || ay != 0) begin
          m = int_sqrt(magn(ax) * magn(ax) + magn(ay) * magn(ay));
          vx = signed_of(ax < 0, magn(ax) * longint'(start) / m);
          vy = signed_of(ay < 0, magn(ay) * longint'(start) / m);
        end
      end else begin
        vx = clamp32(vx + times_dt(ax, dt));
        vy = clamp32(vy + times_dt(ay, dt));
      end
      if (magn(vx) > longint'(limit)) vx = (vx < 0) ? -longint'(limit) : longint'(limit);
      // ground friction never reverses the body
      if (fx == 0 && fy == 0 && vx != 0 && ground) begin
        f = times_dt(over_mass(fric), dt);
        if (longint'(magn(vx)) < f) vx = 0;
        else vx = (vx < 0) ? vx + f : vx - f;
      end
      vel_x = int'(clamp32(vx));
      vel_y = int'(clamp32(vy));
      pos_x = int'(clamp32(longint'(pos_x) + times_dt(vel_x, dt)));
      pos_y = int'(clamp32(longint'(pos_y) + times_dt(vel_y, dt)));
      w.pos_x = pos_x;
      w.pos_y = pos_y;
      w.vel_x = vel_x;
      w.vel_y = vel_y;
      motion_q.push_back(w);
    endfunction

    function void compare(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_word(int px, int py, int vx, int vy);
      motion_t w;
      if (motion_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word expected none actual %0d %0d %0d %0d",
                 $time, px, py, vx, vy);
        return;
      end
      w = motion_q.pop_front();
      compare("pos_x", w.pos_x, px);
      compare("pos_y", w.pos_y, py);
      compare("vel_x", w.vel_x, vx);
      compare("vel_y", w.vel_y, vy);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [pbms_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] force_x_i = '0;
  logic signed [31:0] force_y_i = '0;
  logic [16:0] time_step_i = '0;
  logic on_ground_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] pos_x_o, pos_y_o, vel_x_o, vel_y_o;

  motion_scoreboard sb = new();
  bit no_idle = 1'b0;
  int unsigned cycles = 0;

  planar_body_motion_step_top u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .force_x_i(force_x_i),
    .force_y_i(force_y_i),
    .time_step_i(time_step_i),
    .on_ground_i(on_ground_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pos_x_o(pos_x_o),
    .pos_y_o(pos_y_o),
    .vel_x_o(vel_x_o),
    .vel_y_o(vel_y_o)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side: random stall, check every accepted word
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word(pos_x_o, pos_y_o, vel_x_o, vel_y_o);
    out_stall_i <= !no_idle && ($urandom_range(0, 99) < 33);
  end

  task automatic write_reg(pbms_pkg::cfg_idx_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  task automatic setup(logic [31:0] m, logic [31:0] st, logic [31:0] lim, logic [31:0] fr,
                       logic [31:0] gen, logic [31:0] gx, logic [31:0] gy);
    write_reg(pbms_pkg::CFG_MASS, m);
    write_reg(pbms_pkg::CFG_START, st);
    write_reg(pbms_pkg::CFG_LIMIT, lim);
    write_reg(pbms_pkg::CFG_FRIC, fr);
    write_reg(pbms_pkg::CFG_GEN, gen);
    write_reg(pbms_pkg::CFG_GX, gx);
    write_reg(pbms_pkg::CFG_GY, gy);
  endtask

  // wait until every expected word is in, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.motion_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // one input word; valid is left high so back to back words need no gap
  task automatic send_tick(int fx, int fy, logic [16:0] dt, bit ground);
    while (!no_idle && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    force_x_i <= fx;
    force_y_i <= fy;
    time_step_i <= dt;
    on_ground_i <= ground;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_tick(fx, fy, dt, ground);
  endtask

  function automatic int rand_force();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 27) return int'($urandom());
    return $urandom_range(0, 8 << 16) - (4 << 16);
  endfunction

  task automatic random_ticks(int n);
    int fx, fy;
    logic [16:0] dt;
    for (int i = 0; i < n; i++) begin
      fx = rand_force();
      fy = rand_force();
      // unforced ticks on the ground bring the body to rest
      if ($urandom_range(0, 99) < 20) begin
        fx = 0;
        fy = 0;
      end
      dt = ($urandom_range(0, 9) == 0) ? 17'($urandom()) : 17'($urandom_range(0, 65536));
      send_tick(fx, fy, dt, $urandom_range(0, 1));
      if (i % 97 == 96) drain();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes of fields, launch, clamp, friction, gravity
    setup(32'd65536, 32'd65536, 32'd10 << 16, 32'd32768, 32'd1, 32'd0, -32'sd642253);
    send_tick(0, 0, 17'd65536, 1'b1);
    send_tick(32'sd65536, 0, 17'd65536, 1'b1);
    send_tick(0, 0, 17'd65536, 1'b1);
    send_tick(0, 0, 17'd32768, 1'b1);
    send_tick(0, 0, 17'd65536, 1'b1);
    send_tick(32'sd7 << 16, -32'sd3 << 16, 17'd16384, 1'b0);
    send_tick(32'h7fff_ffff, 32'h7fff_ffff, 17'd65536, 1'b0);
    send_tick(32'h8000_0000, 32'h8000_0000, 17'h1ffff, 1'b0);
    send_tick(32'h8000_0000, 32'h7fff_ffff, 17'h1ffff, 1'b1);
    send_tick(0, 0, 17'd0, 1'b0);
    send_tick(0, 0, 17'h1ffff, 1'b1);
    send_tick(0, 0, 17'd65536, 1'b1);
    send_tick(-32'sd1, 32'sd1, 17'd1, 1'b0);
    send_tick(0, 0, 17'd65536, 1'b1);
    send_tick(0, 0, 17'd65536, 1'b0);
    send_tick(32'sd1, 0, 17'd65536, 1'b1);
    drain();

    // extremes of the registers
    setup(32'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff,
          32'h8000_0000);
    send_tick(32'sd1, 32'sd1, 17'd65536, 1'b0);
    send_tick(0, 0, 17'd65536, 1'b1);
    send_tick(0, 0, 17'h1ffff, 1'b0);
    drain();
    setup(32'h7fff_ffff, 32'd0, 32'd0, 32'd0, 32'd0, 32'h8000_0000, 32'h7fff_ffff);
    send_tick(32'h7fff_ffff, 32'h8000_0000, 17'd65536, 1'b0);
    send_tick(32'sd5 << 16, 0, 17'd65536, 1'b1);
    drain();

    // random phases under several settings
    setup(32'd65536, 32'd65536, 32'd20 << 16, 32'd65536, 32'd1, 32'd0, -32'sd642253);
    random_ticks(230);
    drain();
    setup(32'd2 << 16, 32'd3 << 16, 32'd5 << 16, 32'd1 << 16, 32'd1, 32'sd1 << 15,
          32'sd2 << 16);
    no_idle = 1'b1;
    random_ticks(230);
    no_idle = 1'b0;
    drain();
    setup(32'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0, 32'd0, 32'd0);
    random_ticks(210);
    drain();
    setup(32'h7fff_ffff, 32'd0, 32'd0, 32'd0, 32'd1, 32'h7fff_ffff, 32'h8000_0000);
    random_ticks(210);
    drain();
    setup(32'd16384, 32'd1 << 12, 32'd100 << 16, 32'd8 << 16, 32'd1, -32'sd1 << 16,
          32'sd3 << 14);
    random_ticks(230);
    drain();
    setup($urandom_range(1, 32'h7fff_ffff), $urandom(), $urandom(), $urandom(),
          $urandom(), $urandom(), $urandom());
    random_ticks(230);

    drain();
    if (sb.errors == 0 && sb.motion_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== planar_body_motion_step_top.f =====
+incdir+src
src/pbms_pkg.sv
src/planar_body_motion_step_top.sv
src/pbms_checker.sv
verif/tb.sv
